/* rtl/core/cvwg_pkg.sv */
// ----------------------------------------------------------------------------
// cvwg_pkg
// Shared types and constants for the control-voltage waveform generator:
// register indexes, mode and shape codes, field widths and level limits.
// ----------------------------------------------------------------------------
package cvwg_pkg;

    // field widths
    localparam int unsigned ELAPSED_W  = 32;
    localparam int unsigned LEVEL_W    = 15;
    localparam int unsigned WAVE_W     = 16;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // stream data widths, rounded up to whole bytes
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 16;

    typedef logic [LEVEL_W-1:0]        t_level;
    typedef logic signed [WAVE_W-1:0]  t_wave;
    typedef logic [CFG_ADDR_W-1:0]     t_cfg_addr;

    // register indexes
    localparam t_cfg_addr CFG_SOURCE_MODE    = 3'd0;
    localparam t_cfg_addr CFG_WAVE_SHAPE     = 3'd1;
    localparam t_cfg_addr CFG_MANUAL_LEVEL   = 3'd2;
    localparam t_cfg_addr CFG_BIAS_LEVEL     = 3'd3;
    localparam t_cfg_addr CFG_WAVE_AMPLITUDE = 3'd4;
    localparam t_cfg_addr CFG_TONE_FREQUENCY = 3'd5;

    // source modes
    localparam logic SRC_MANUAL    = 1'b0;
    localparam logic SRC_GENERATOR = 1'b1;

    // wave shapes
    localparam logic [1:0] SHAPE_SINE     = 2'd0;
    localparam logic [1:0] SHAPE_TRIANGLE = 2'd1;
    localparam logic [1:0] SHAPE_SQUARE   = 2'd2;
    localparam logic [1:0] SHAPE_SAW      = 2'd3;

    // output level range, 1/4096 V units (0..5 V)
    localparam t_level LEVEL_MAX = 15'd20480;

    // q1.15 wave limits
    localparam t_wave WAVE_POS_MAX = 16'sd32767;
    localparam t_wave WAVE_NEG_MAX = -16'sd32768;

    // pi/2 in q30, used to build the quarter-wave table
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // phase increment: q16.16 frequency times q8.24 time gives 40 fraction bits,
    // padded so that phase widths up to 48 bits take a plain slice
    localparam int unsigned INC_PROD_W   = 64;
    localparam int unsigned INC_FRAC     = 40;
    localparam int unsigned PHASE_MAX_W  = 48;
    localparam int unsigned INC_PAD      = PHASE_MAX_W - INC_FRAC;

endpackage

/* rtl/core/cv_waveform_generator.sv */
// ----------------------------------------------------------------------------
// cv_waveform_generator
// Control-voltage source on a phase-accumulator oscillator: manual level or
// bias + amplitude * wave(phase), clamped to 0..5 V in 1/4096 V units.
// ----------------------------------------------------------------------------
// Usage:
//   Each transaction on the slave stream carries the elapsed time since the
//   last tick (q8.24 s); each one yields exactly one transaction on the master
//   stream with the output level (0..20480). In generator mode the level comes
//   from the phase before this tick, then the phase advances by
//   frequency * elapsed; in manual mode the phase holds.
//   Registers must be written through i_cfg_we/i_cfg_addr/i_cfg_data while
//   the block is idle (not enforced); a write takes effect at the next clock edge.
// Timing:
//   Six register stages (input, increment multiply, phase accumulate, wave
//   lookup, amplitude multiply, output). One transaction per cycle is taken
//   sustained while the receiver does not stall; the phase accumulate loop
//   holds a single register.
// Reset and stall:
//   Reset clears the configuration registers, the phase and the pipeline
//   valid bits. When the receiver stalls, the output holds and the stages
//   behind it keep filling their empty slots, so tready falls only once every
//   stage holds a result.
// ----------------------------------------------------------------------------
module cv_waveform_generator #(
    parameter int unsigned SINE_TABLE_DEPTH = 256,
    parameter int unsigned PHASE_BITS       = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [cvwg_pkg::S_TDATA_W-1:0] i_s_axis_tdata,  // [31:0] elapsed_time
    // master stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [cvwg_pkg::M_TDATA_W-1:0] o_m_axis_tdata,  // [14:0] out_level, [15] zero
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [cvwg_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [cvwg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cvwg_pkg::*;

    localparam int unsigned IDX_W  = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
    localparam int unsigned IPW    = 14 + IDX_W + 1;
    localparam int unsigned INC_LO = PHASE_MAX_W - PHASE_BITS;

    // quarter-wave sine entry, sin(pi/2 * i / depth) in q1.15, taylor series in q30
    function automatic logic [14:0] sine_entry(input int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        logic [63:0] r;
        x    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        r = ((64'(sum) * 64'd32767) + 64'd536870912) >> 30;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[14:0];
    endfunction

    // constant quarter-wave table
    logic [14:0] w_sine_rom [SINE_TABLE_DEPTH];
    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sine_rom
        assign w_sine_rom[g] = sine_entry(g);
    end

    // configuration registers
    logic                      r_source_mode;
    logic [1:0]                r_wave_shape;
    logic signed [15:0]        r_manual_level;
    logic signed [15:0]        r_bias_level;
    logic signed [15:0]        r_wave_amplitude;
    logic [31:0]               r_tone_frequency;

    // pipeline registers
    logic                      r_s1_valid;
    logic [ELAPSED_W-1:0]      r_s1_elapsed;
    logic                      r_s2_valid;
    logic [PHASE_BITS-1:0]     r_s2_inc;
    logic                      r_s3_valid;
    logic [15:0]               r_s3_p;
    logic                      r_s4_valid;
    t_wave                     r_s4_wave;
    logic                      r_s5_valid;
    logic signed [31:0]        r_s5_prod;
    logic                      r_out_valid;
    t_level                    r_out_level;
    logic [PHASE_BITS-1:0]     r_phase;

    // stage enables, a stage moves when it is empty or its successor moves
    logic w_en_out, w_en_s5, w_en_s4, w_en_s3, w_en_s2, w_en_s1;
    assign w_en_out = !r_out_valid || i_m_axis_tready;
    assign w_en_s5  = !r_s5_valid  || w_en_out;
    assign w_en_s4  = !r_s4_valid  || w_en_s5;
    assign w_en_s3  = !r_s3_valid  || w_en_s4;
    assign w_en_s2  = !r_s2_valid  || w_en_s3;
    assign w_en_s1  = !r_s1_valid  || w_en_s2;

    assign o_s_axis_tready = w_en_s1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W-LEVEL_W){1'b0}}, r_out_level};

    // configuration decoder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_mode    <= SRC_MANUAL;
            r_wave_shape     <= SHAPE_SINE;
            r_manual_level   <= '0;
            r_bias_level     <= '0;
            r_wave_amplitude <= '0;
            r_tone_frequency <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SOURCE_MODE:    r_source_mode    <= i_cfg_data[0];
                CFG_WAVE_SHAPE:     r_wave_shape     <= i_cfg_data[1:0];
                CFG_MANUAL_LEVEL:   r_manual_level   <= $signed(i_cfg_data[15:0]);
                CFG_BIAS_LEVEL:     r_bias_level     <= $signed(i_cfg_data[15:0]);
                CFG_WAVE_AMPLITUDE: r_wave_amplitude <= $signed(i_cfg_data[15:0]);
                CFG_TONE_FREQUENCY: r_tone_frequency <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // increment multiply, q16.16 * q8.24, sliced to the phase fraction
    logic [INC_PROD_W-1:0]         n_inc_prod;
    logic [INC_PROD_W+INC_PAD-1:0] n_inc_ext;
    logic [PHASE_BITS-1:0]         n_s2_inc;
    assign n_inc_prod = INC_PROD_W'(r_tone_frequency) * INC_PROD_W'(r_s1_elapsed);
    assign n_inc_ext  = {n_inc_prod, {INC_PAD{1'b0}}};
    assign n_s2_inc   = n_inc_ext[INC_LO +: PHASE_BITS];

    // sine lookup position: falling quadrants mirror the fraction
    logic [1:0]       w_quad;
    logic [13:0]      w_frac;
    logic [13:0]      w_pos;
    logic             w_peak;
    logic [IPW-1:0]   w_idx_prod;
    logic [IDX_W-1:0] w_idx;
    logic [14:0]      w_sine_mag;
    assign w_quad     = r_s3_p[15:14];
    assign w_frac     = r_s3_p[13:0];
    assign w_pos      = w_quad[0] ? (14'd0 - w_frac) : w_frac;
    assign w_peak     = w_quad[0] && (w_frac == 14'd0);
    assign w_idx_prod = IPW'(w_pos) * IPW'(SINE_TABLE_DEPTH);
    assign w_idx      = w_idx_prod[14 +: IDX_W];
    assign w_sine_mag = w_peak ? 15'd32767 : w_sine_rom[w_idx];

    // wave shape select
    logic signed [16:0] w_tri_d;
    logic [16:0]        w_tri_abs;
    logic signed [17:0] w_tri_v;
    t_wave              w_sine_pos;
    t_wave              n_s4_wave;
    assign w_tri_d    = $signed({1'b0, r_s3_p}) - 17'sd32768;
    assign w_tri_abs  = w_tri_d[16] ? 17'(-w_tri_d) : 17'(w_tri_d);
    // full distance kept so the start of the cycle reaches -1
    assign w_tri_v    = 18'sd32768 - $signed({w_tri_abs, 1'b0});
    assign w_sine_pos = $signed({1'b0, w_sine_mag});

    always_comb begin
        case (r_wave_shape)
            SHAPE_SINE:     n_s4_wave = w_quad[1] ? -w_sine_pos : w_sine_pos;
            SHAPE_TRIANGLE: n_s4_wave = (w_tri_v > 18'sd32767) ? WAVE_POS_MAX
                                                               : t_wave'(w_tri_v);
            SHAPE_SQUARE:   n_s4_wave = r_s3_p[15] ? WAVE_POS_MAX : WAVE_NEG_MAX;
            default:        n_s4_wave = $signed({~r_s3_p[15], r_s3_p[14:0]});
        endcase
    end

    // round, add bias and clamp
    logic signed [32:0] w_round;
    logic signed [17:0] w_scaled;
    logic signed [18:0] w_gen_level;
    logic signed [18:0] w_sel_level;
    t_level             n_out_level;
    assign w_round     = 33'(r_s5_prod) + 33'sd16384;
    assign w_scaled    = 18'(w_round >>> 15);
    assign w_gen_level = 19'(w_scaled) + 19'(r_bias_level);
    assign w_sel_level = (r_source_mode == SRC_GENERATOR) ? w_gen_level
                                                          : 19'(r_manual_level);

    always_comb begin
        if (w_sel_level < 19'sd0) begin
            n_out_level = '0;
        end else if (w_sel_level > $signed({4'b0, LEVEL_MAX})) begin
            n_out_level = LEVEL_MAX;
        end else begin
            n_out_level = w_sel_level[LEVEL_W-1:0];
        end
    end

    // pipeline valid bits and phase accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= '0;
        end else begin
            if (w_en_s1)  r_s1_valid  <= i_s_axis_tvalid;
            if (w_en_s2)  r_s2_valid  <= r_s1_valid;
            if (w_en_s3)  r_s3_valid  <= r_s2_valid;
            if (w_en_s4)  r_s4_valid  <= r_s3_valid;
            if (w_en_s5)  r_s5_valid  <= r_s4_valid;
            if (w_en_out) r_out_valid <= r_s5_valid;
            // phase moves as its transaction leaves the increment stage
            if (w_en_s3 && r_s2_valid && (r_source_mode == SRC_GENERATOR)) begin
                r_phase <= r_phase + r_s2_inc;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_en_s1)  r_s1_elapsed <= i_s_axis_tdata[ELAPSED_W-1:0];
        if (w_en_s2)  r_s2_inc     <= n_s2_inc;
        if (w_en_s3)  r_s3_p       <= r_phase[PHASE_BITS-1 -: 16];
        if (w_en_s4)  r_s4_wave    <= n_s4_wave;
        if (w_en_s5)  r_s5_prod    <= 32'(r_wave_amplitude) * 32'(r_s4_wave);
        if (w_en_out) r_out_level  <= n_out_level;
    end

    // checks
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[LEVEL_W-1:0] <= LEVEL_MAX))
        else $error("output level above 5 V");

    a_manual_phase_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_source_mode == SRC_MANUAL) |=> $stable(r_phase))
        else $error("phase moved in manual mode");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with an empty output");

endmodule
